// ----- rtl/rtn_pkg.sv -----
`default_nettype none

package rtn_pkg;

  localparam int unsigned MAX_WIDTH_DEFAULT = 4096;

  // line_width register
  localparam int unsigned LINE_WIDTH_W = 13;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd640;

  // effective row width is compared in this many bits (holds up to 32767)
  localparam int unsigned EFF_WIDTH_W = 15;

  // pair / block sums of 8-bit chroma
  localparam int unsigned PAIR_SUM_W = 9;
  localparam int unsigned PAIR_ENTRY_W = 2 * PAIR_SUM_W;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       odd_col;
    logic       odd_row;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] v_average;
    logic [7:0] u_average;
  } result_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
    logic out_push;
    logic out_full;
  } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/rtn_queue.sv -----
`default_nettype none

module rtn_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rtn_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign empty    = (wr_ptr == rd_ptr);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + (AW+1)'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr[AW-1:0]] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rtn_ram.sv -----
`default_nettype none

module rtn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rtn_front.sv -----
`default_nettype none

module rtn_front #(
  parameter int unsigned MAX_WIDTH = rtn_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned COL_W     = 12,
  parameter int unsigned IDX_W     = 11
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              line_width_write,
  input  wire logic [rtn_pkg::LINE_WIDTH_W-1:0]  line_width,
  input  wire logic                              push,
  input  wire logic [7:0]                        red,
  input  wire logic [7:0]                        green,
  input  wire logic [7:0]                        blue,
  input  wire logic                              frame_start,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output rtn_pkg::pixel_item_t                   q_item,
  output logic      [IDX_W-1:0]                  q_idx
);

  localparam int unsigned EW = rtn_pkg::EFF_WIDTH_W;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

  logic [rtn_pkg::LINE_WIDTH_W-1:0] width_reg;
  logic [COL_W-1:0]                 column;
  logic                             odd_row;
  logic [rtn_pkg::LINE_WIDTH_W-1:0] width_even;
  logic [EW-1:0]                    eff_width;
  logic [COL_W-1:0]                 cur_col;
  logic                             cur_odd;
  logic [EW-1:0]                    col_inc;
  logic                             wrap;

  always_comb begin
    width_even = {width_reg[rtn_pkg::LINE_WIDTH_W-1:1], 1'b0};
    if (width_even == '0) begin
      eff_width = EW'(2);
    end else if (EW'(width_even) > MAXW) begin
      eff_width = MAXW;
    end else begin
      eff_width = EW'(width_even);
    end
  end

  // frame_start restarts the raster before this pixel is placed
  assign cur_col = frame_start ? '0 : column;
  assign cur_odd = frame_start ? 1'b0 : odd_row;
  assign col_inc = EW'(cur_col) + EW'(1);
  assign wrap    = (col_inc >= eff_width);

  assign q_push          = push && !q_full;
  assign q_item.red      = red;
  assign q_item.green    = green;
  assign q_item.blue     = blue;
  assign q_item.odd_col  = cur_col[0];
  assign q_item.odd_row  = cur_odd;
  assign q_idx           = IDX_W'(cur_col >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= rtn_pkg::LINE_WIDTH_RESET;
      column    <= '0;
      odd_row   <= 1'b0;
    end else begin
      if (line_width_write) begin
        width_reg <= line_width;
      end
      if (q_push) begin
        column  <= wrap ? '0 : COL_W'(col_inc);
        odd_row <= cur_odd ^ wrap;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rtn_back.sv -----
`default_nettype none

module rtn_back #(
  parameter int unsigned MAX_WIDTH = rtn_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned IDX_W     = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_empty,
  input  wire rtn_pkg::pixel_item_t  in_item,
  input  wire logic [IDX_W-1:0]      in_idx,
  output logic                       in_pop,
  input  wire logic                  out_full,
  output logic                       out_push,
  output rtn_pkg::result_t           out_result,
  output rtn_pkg::back_status_t      status
);

  localparam int unsigned SW = rtn_pkg::PAIR_SUM_W;
  localparam int unsigned EW = rtn_pkg::PAIR_ENTRY_W;

  logic        en;

  // stage 1: colour conversion
  logic [16:0] y_sum;
  logic [16:0] cb_sum;
  logic [16:0] cr_sum;
  logic [8:0]  y_pre;
  logic [7:0]  y_calc;
  logic [7:0]  cb_calc;
  logic [7:0]  cr_calc;

  logic             s1_valid;
  logic             s1_odd_col;
  logic             s1_odd_row;
  logic [IDX_W-1:0] s1_idx;
  logic [7:0]       s1_luma;
  logic [7:0]       s1_cb;
  logic [7:0]       s1_cr;

  // stage 2: pairing and line store
  logic [7:0]    pending_cr;
  logic [7:0]    pending_cb;
  logic [SW-1:0] pair_cr;
  logic [SW-1:0] pair_cb;
  logic          ram_we;
  logic          ram_re;
  logic [EW-1:0] ram_rdata;

  logic          s2_valid;
  logic [7:0]    s2_luma;
  logic          s2_chroma;
  logic [SW-1:0] s2_pair_cr;
  logic [SW-1:0] s2_pair_cb;

  // stage 3: block average
  logic [SW+1:0] blk_cr;
  logic [SW+1:0] blk_cb;
  logic [SW-1:0] v_pre;
  logic [SW-1:0] u_pre;

  assign en     = !(s2_valid && out_full);
  assign in_pop = en && !in_empty;

  // offsets of 128 << 8 keep the chroma sums non-negative
  always_comb begin
    y_sum  = 17'(in_item.red) * 17'd66 + 17'(in_item.green) * 17'd129
           + 17'(in_item.blue) * 17'd25 + 17'd128;
    cb_sum = 17'(in_item.blue) * 17'd112 + 17'd32896
           - 17'(in_item.red) * 17'd38 - 17'(in_item.green) * 17'd74;
    cr_sum = 17'(in_item.red) * 17'd112 + 17'd32896
           - 17'(in_item.green) * 17'd94 - 17'(in_item.blue) * 17'd18;
    y_pre  = 9'(y_sum[16:8]) + 9'd16;
    y_calc = y_pre[8] ? 8'd255 : y_pre[7:0];
    cb_calc = cb_sum[16] ? 8'd255 : cb_sum[15:8];
    cr_calc = cr_sum[16] ? 8'd255 : cr_sum[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= !in_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      s1_odd_col <= in_item.odd_col;
      s1_odd_row <= in_item.odd_row;
      s1_idx     <= in_idx;
      s1_luma    <= y_calc;
      s1_cb      <= cb_calc;
      s1_cr      <= cr_calc;
    end
  end

  assign pair_cr = SW'(pending_cr) + SW'(s1_cr);
  assign pair_cb = SW'(pending_cb) + SW'(s1_cb);
  assign ram_we  = en && s1_valid && s1_odd_col && !s1_odd_row;
  assign ram_re  = en && s1_valid && s1_odd_col && s1_odd_row;

  rtn_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH / 2)
  ) u_pair_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata ({pair_cb, pair_cr}),
    .re    (ram_re),
    .raddr (s1_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cr <= '0;
      pending_cb <= '0;
      s2_valid   <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      if (s1_valid && !s1_odd_col) begin
        pending_cr <= s1_cr;
        pending_cb <= s1_cb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_luma    <= s1_luma;
      s2_chroma  <= s1_odd_col && s1_odd_row;
      s2_pair_cr <= pair_cr;
      s2_pair_cb <= pair_cb;
    end
  end

  always_comb begin
    blk_cr = (SW+2)'(ram_rdata[SW-1:0]) + (SW+2)'(s2_pair_cr) + (SW+2)'(2);
    blk_cb = (SW+2)'(ram_rdata[EW-1:SW]) + (SW+2)'(s2_pair_cb) + (SW+2)'(2);
    v_pre  = blk_cr[SW+1:2];
    u_pre  = blk_cb[SW+1:2];
    out_result.luma         = s2_luma;
    out_result.chroma_valid = s2_chroma;
    out_result.v_average    = !s2_chroma ? 8'd0 : (v_pre[SW-1] ? 8'd255 : v_pre[7:0]);
    out_result.u_average    = !s2_chroma ? 8'd0 : (u_pre[SW-1] ? 8'd255 : u_pre[7:0]);
  end

  assign out_push = s2_valid && !out_full;

  assign status.s1_valid = s1_valid;
  assign status.s2_valid = s2_valid;
  assign status.out_push = out_push;
  assign status.out_full = out_full;

endmodule

`default_nettype wire

// ----- rtl/rgb_to_nv21_bt601_converter.sv -----
// RGB to NV21 (BT.601 limited range) stream converter.
// Input channel: present red/green/blue/frame_start with push; a transfer
// happens on a clock edge with push high and full low. Pixels come in raster
// order; frame_start on a pixel puts it at row 0, column 0.
// Result channel: while empty is low the oldest result sits on luma,
// chroma_valid, v_average and u_average; pop high transfers it. One result
// per pixel; chroma_valid marks the second pixel of a pair on an odd row,
// which carries the rounded 2x2 V and U averages (zero otherwise).
// line_width is written with line_width_write, only while the block is idle;
// the user must keep to that, the block does not enforce it. Throughput is
// one pixel per clock while the result queue does not fill; the pair store,
// with one write port, is written or read once per pixel pair by the back end.
// A 4-entry queue sits between the position tracking front and the
// conversion back; a 4-entry result queue follows. When pop is held low the
// result queue fills, the back pipeline freezes, then the front queue fills
// and full rises. Reset empties both queues, zeroes position and pending
// chroma and sets line_width to 640; the pair store is not cleared.
`default_nettype none

module rgb_to_nv21_bt601_converter #(
  parameter int unsigned MAX_WIDTH = rtn_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             line_width_write,
  input  wire logic [rtn_pkg::LINE_WIDTH_W-1:0] line_width,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [7:0]                       red,
  input  wire logic [7:0]                       green,
  input  wire logic [7:0]                       blue,
  input  wire logic                             frame_start,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic      [7:0]                       luma,
  output logic                                  chroma_valid,
  output logic      [7:0]                       v_average,
  output logic      [7:0]                       u_average
);

  localparam int unsigned COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned IDX_W  = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int unsigned ITEM_W = $bits(rtn_pkg::pixel_item_t) + IDX_W;
  localparam int unsigned RES_W  = $bits(rtn_pkg::result_t);

  logic                  fq_full;
  logic                  fq_push;
  rtn_pkg::pixel_item_t  f_item;
  logic [IDX_W-1:0]      f_idx;
  logic [ITEM_W-1:0]     fq_head;
  logic                  fq_empty;
  logic                  fq_pop;
  rtn_pkg::pixel_item_t  b_item;
  logic [IDX_W-1:0]      b_idx;

  logic                  rq_push;
  logic                  rq_full;
  rtn_pkg::result_t      b_result;
  rtn_pkg::result_t      rq_head;
  rtn_pkg::back_status_t back_st;

  assign full = fq_full;

  rtn_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .line_width_write (line_width_write),
    .line_width       (line_width),
    .push             (push),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .frame_start      (frame_start),
    .q_full           (fq_full),
    .q_push           (fq_push),
    .q_item           (f_item),
    .q_idx            (f_idx)
  );

  rtn_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (rtn_pkg::QUEUE_DEPTH)
  ) u_item_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_data ({f_item, f_idx}),
    .full      (fq_full),
    .pop       (fq_pop),
    .pop_data  (fq_head),
    .empty     (fq_empty)
  );

  assign b_item = rtn_pkg::pixel_item_t'(fq_head[ITEM_W-1:IDX_W]);
  assign b_idx  = fq_head[IDX_W-1:0];

  rtn_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_empty   (fq_empty),
    .in_item    (b_item),
    .in_idx     (b_idx),
    .in_pop     (fq_pop),
    .out_full   (rq_full),
    .out_push   (rq_push),
    .out_result (b_result),
    .status     (back_st)
  );

  rtn_queue #(
    .WIDTH (RES_W),
    .DEPTH (rtn_pkg::QUEUE_DEPTH)
  ) u_result_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .push_data (b_result),
    .full      (rq_full),
    .pop       (pop),
    .pop_data  (rq_head),
    .empty     (empty)
  );

  assign luma         = rq_head.luma;
  assign chroma_valid = rq_head.chroma_valid;
  assign v_average    = rq_head.v_average;
  assign u_average    = rq_head.u_average;

  // a stalled back end keeps its last stage occupied
  assert property (@(posedge clk) disable iff (rst)
    back_st.s2_valid && back_st.out_full |=> back_st.s2_valid)
    else $error("back pipeline dropped a stalled result");

  // when not stalled the last stage takes whatever the first stage held
  assert property (@(posedge clk) disable iff (rst)
    !(back_st.s2_valid && back_st.out_full) |=> back_st.s2_valid == $past(back_st.s1_valid))
    else $error("back pipeline lost or repeated an item");

  // a result transfer into the result queue needs a valid, unstalled stage
  assert property (@(posedge clk) disable iff (rst)
    back_st.out_push |-> back_st.s2_valid && !back_st.out_full)
    else $error("result pushed without a valid stage");

  // chroma fields read zero on pixels that do not close a block
  assert property (@(posedge clk) disable iff (rst)
    !empty && !chroma_valid |-> v_average == 8'd0 && u_average == 8'd0)
    else $error("chroma fields set without chroma_valid");

  // reset leaves both queues empty
  assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

endmodule

`default_nettype wire
